>>> hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator: operation,
// status and register codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Field widths fixed by the block interface
  localparam int unsigned BLK_W = 15;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned CFG_W = 16;

  // Largest block count that granted_block can name
  localparam int unsigned GRANT_SPAN = 32768;

  localparam logic [CNT_W-1:0] COUNTER_RESET    = 16'd31735;
  localparam logic [CNT_W-1:0] COUNTER_MAX      = 16'hFFFF;
  localparam logic [CFG_W-1:0] FIRST_DATA_RESET = 16'd1033;
  localparam logic [CFG_W-1:0] LIMIT_RESET      = 16'd32768;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic {
    CFG_FIRST_DATA  = 1'b0,
    CFG_BLOCK_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_DONE         = 2'd0,
    STAT_NO_FREE      = 2'd1,
    STAT_OUT_OF_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SCAN,
    ST_ENC,
    ST_ALLOC_WR,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_FINISH
  } bba_state_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;        // latch the input beat
    logic    clr_wr;      // write a zero word, advance the clear address
    logic    div_start;   // start splitting a block number into word and bit
    logic    scan_init;   // load word address and base from the divider
    logic    scan;        // issue map reads and check returned words
    logic    enc;         // pick the lowest free bit of the held word
    logic    alloc_wr;    // set the picked bit, decrement the counter
    logic    free_wr;     // clear the freed bit, increment the counter
    logic    set_status;  // record a failure status
    status_e status_code;
    logic    out_load;    // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;    // clear address at last map word
    logic reject;      // request fails its range check
    logic op_free;     // held request is a free
    logic div_done;    // divider finished
    logic chk_hit;     // checked word has an eligible clear bit
    logic scan_empty;  // nothing left to read or check
  } sts_t;

endpackage

>>> hdl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: clearing pass, range check, divide, map scan
// or read-modify-write, and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  bba_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:    state_d = sts_i.reject ? ST_FINISH : ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = sts_i.op_free ? ST_FREE_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.chk_hit) begin
          state_d = ST_ENC;
        end else if (sts_i.scan_empty) begin
          state_d = ST_FINISH;
        end
      end
      ST_ENC:      state_d = ST_ALLOC_WR;
      ST_ALLOC_WR: state_d = ST_FINISH;
      ST_FREE_RD:  state_d = ST_FREE_WR;
      ST_FREE_WR:  state_d = ST_FINISH;
      ST_FINISH:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o             = '0;
    cmd_o.status_code = STAT_DONE;
    in_ready_o        = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        if (sts_i.reject) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = sts_i.op_free ? STAT_OUT_OF_RANGE : STAT_NO_FREE;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      ST_DIV: cmd_o.scan_init = sts_i.div_done;
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (!sts_i.chk_hit && sts_i.scan_empty) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = STAT_NO_FREE;
        end
      end
      ST_ENC:      cmd_o.enc = 1'b1;
      ST_ALLOC_WR: cmd_o.alloc_wr = 1'b1;
      ST_FREE_RD:  cmd_o.scan = 1'b0;
      ST_FREE_WR:  cmd_o.free_wr = 1'b1;
      ST_FINISH:   cmd_o.out_load = !out_valid_q || out_ready_i;
      default:     cmd_o = '0;
    endcase
  end

  // Output beat valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result raised outside the finish state");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o && !cmd_o.load)
    else $error("input beat taken during the clearing pass");

endmodule

>>> hdl/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Datapath of the allocator: configuration registers, free counter,
// reciprocal block-number divider, occupancy map RAM with its scan and check
// stages, lowest-free-bit encoder and result registers.
// ----------------------------------------------------------------------------
module bba_dp
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS    = 32768,
  parameter int unsigned MAP_WORD_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             operation_i,
  input  logic [BLK_W-1:0] block_number_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic [1:0]       status_o,
  output logic [BLK_W-1:0] granted_block_o,
  output logic [CNT_W-1:0] free_count_o
);

  localparam int unsigned LimCapInt = (NUM_BLOCKS < GRANT_SPAN) ? NUM_BLOCKS : GRANT_SPAN;
  localparam int unsigned MapWords  = (LimCapInt + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned AddrW     = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned BitW      = $clog2(MAP_WORD_BITS);
  localparam int unsigned WordW     = MAP_WORD_BITS;

  // Reciprocal of the word size: exact quotient for any 15-bit block number
  localparam int unsigned RecipShift = BLK_W + BitW;
  localparam int unsigned ProdW      = BLK_W + BLK_W + 2;
  localparam int unsigned RecipInt   = ((1 << RecipShift) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  localparam logic [CFG_W-1:0] LimCap   = CFG_W'(LimCapInt);
  localparam logic [CFG_W-1:0] WordStep = CFG_W'(MAP_WORD_BITS);
  localparam logic [BLK_W+1:0] Recip    = (BLK_W + 2)'(RecipInt);
  localparam logic [BLK_W-1:0] WordDiv  = BLK_W'(MAP_WORD_BITS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MapWords - 1);
  localparam logic [WordW-1:0] OneBit   = WordW'(1);

  // Held request and configuration
  op_e              op_q;
  logic [BLK_W-1:0] blk_q;
  logic [CFG_W-1:0] first_data_q, block_limit_q;
  logic [CNT_W-1:0] free_cnt_q;
  logic [CFG_W-1:0] lim;

  // Divider
  logic [BLK_W-1:0] div_quo_q, div_op, div_back, div_diff;
  logic [BitW-1:0]  div_rem_q;
  logic             div_pend_q;
  logic [ProdW-1:0] div_prod;

  // Scan issue and check stages
  logic [AddrW-1:0] addr_q, chk_addr_q, hold_addr_q;
  logic [CFG_W-1:0] base_q, chk_base_q, hold_base_q, span;
  logic             first_q, chk_first_q, chk_vld_q, issue_ok;
  logic [WordW-1:0] rdata, avail, avail_q, hold_data_q;
  logic [BitW-1:0]  idx_c, idx_q;

  // RAM write port
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata;

  // Result
  status_e          res_status_q;
  logic [BLK_W-1:0] grant_q;

  // Effective limit and range checks
  always_comb begin
    lim = (block_limit_q > LimCap) ? LimCap : block_limit_q;
  end

  assign sts_o.op_free  = (op_q == OP_FREE);
  assign sts_o.reject   = (op_q == OP_ALLOC) ? (first_data_q >= lim)
                        : (({1'b0, blk_q} < first_data_q) || ({1'b0, blk_q} >= lim));
  assign sts_o.clr_last = (addr_q == LastAddr);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_data_q  <= FIRST_DATA_RESET;
      block_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_DATA:  first_data_q  <= cfg_data_i;
        CFG_BLOCK_LIMIT: block_limit_q <= cfg_data_i;
        default:         first_data_q  <= first_data_q;
      endcase
    end
  end

  // Latch the request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      blk_q <= block_number_i;
    end
  end

  // Split a block number into word index and bit offset: the quotient is
  // registered from a reciprocal multiply, then the remainder is registered from it
  assign div_op   = (op_q == OP_FREE) ? blk_q : first_data_q[BLK_W-1:0];
  assign div_prod = ProdW'(div_op) * ProdW'(Recip);
  assign div_back = div_quo_q * WordDiv;
  assign div_diff = div_op - div_back;
  assign sts_o.div_done = !div_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pend_q <= 1'b0;
    end else begin
      div_pend_q <= cmd_i.div_start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_quo_q <= BLK_W'(div_prod[ProdW-1:RecipShift]);
    end
    if (div_pend_q) begin
      div_rem_q <= div_diff[BitW-1:0];
    end
  end

  // Word address: clear sweep, scan issue, free read-modify-write
  assign issue_ok = (base_q < lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      first_q   <= 1'b0;
      chk_vld_q <= 1'b0;
    end else begin
      chk_vld_q <= cmd_i.scan && issue_ok;
      if (cmd_i.clr_wr) begin
        addr_q <= addr_q + AddrW'(1);
      end else if (cmd_i.scan_init) begin
        addr_q  <= div_quo_q[AddrW-1:0];
        first_q <= 1'b1;
      end else if (cmd_i.scan && issue_ok) begin
        addr_q  <= addr_q + AddrW'(1);
        first_q <= 1'b0;
      end
    end
  end

  // Word base and check-stage tags travel alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      base_q <= first_data_q - CFG_W'(div_rem_q);
    end else if (cmd_i.scan && issue_ok) begin
      base_q <= base_q + WordStep;
    end
    chk_first_q <= first_q;
    chk_base_q  <= base_q;
    chk_addr_q  <= addr_q;
  end

  // Eligible clear bits of the returned word
  assign span = lim - chk_base_q;

  always_comb begin
    for (int j = 0; j < WordW; j++) begin
      avail[j] = !rdata[j]
               && (!chk_first_q || (BitW'(j) >= div_rem_q))
               && (CFG_W'(j) < span);
    end
  end

  assign sts_o.chk_hit    = chk_vld_q && (avail != '0);
  assign sts_o.scan_empty = !chk_vld_q && !issue_ok;

  // Hold the word that has a free bit
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && sts_o.chk_hit) begin
      hold_data_q <= rdata;
      avail_q     <= avail;
      hold_base_q <= chk_base_q;
      hold_addr_q <= chk_addr_q;
    end
  end

  // Lowest free bit of the held word
  always_comb begin
    idx_c = '0;
    for (int j = WordW - 1; j >= 0; j--) begin
      if (avail_q[j]) begin
        idx_c = BitW'(j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enc) begin
      idx_q <= idx_c;
    end
  end

  // Map write: zero on clear, set on allocate, clear on free
  always_comb begin
    ram_we    = cmd_i.clr_wr || cmd_i.alloc_wr || cmd_i.free_wr;
    ram_waddr = cmd_i.alloc_wr ? hold_addr_q : addr_q;
    if (cmd_i.clr_wr) begin
      ram_wdata = '0;
    end else if (cmd_i.alloc_wr) begin
      ram_wdata = hold_data_q | (OneBit << idx_q);
    end else begin
      ram_wdata = rdata & ~(OneBit << div_rem_q);
    end
  end

  bba_ram #(
    .Width (WordW),
    .Depth (MapWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // Free-block counter, saturating both ways
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q <= COUNTER_RESET;
    end else if (cmd_i.alloc_wr && (free_cnt_q != '0)) begin
      free_cnt_q <= free_cnt_q - CNT_W'(1);
    end else if (cmd_i.free_wr && (free_cnt_q != COUNTER_MAX)) begin
      free_cnt_q <= free_cnt_q + CNT_W'(1);
    end
  end

  // Result status and granted block
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      grant_q <= '0;
    end else if (cmd_i.alloc_wr) begin
      grant_q <= hold_base_q[BLK_W-1:0] + BLK_W'(idx_q);
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status_code;
    end else if (cmd_i.alloc_wr || cmd_i.free_wr) begin
      res_status_q <= STAT_DONE;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o        <= res_status_q;
      granted_block_o <= grant_q;
      free_count_o    <= free_cnt_q;
    end
  end

  a_alloc_bit_was_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_wr |-> !hold_data_q[idx_q])
    else $error("allocate picked a bit that was already set");

  a_free_counts_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.free_wr && (free_cnt_q != COUNTER_MAX)
      |=> free_cnt_q == CNT_W'($past(free_cnt_q) + CNT_W'(1)))
    else $error("free did not advance the counter");

  a_scan_after_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_init |-> !div_pend_q && !cmd_i.div_start)
    else $error("word address loaded before the divider finished");

endmodule

>>> hdl/bitmap_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a one-bit-per-block occupancy map with a
// free-block counter; one result beat for every request beat.
// ----------------------------------------------------------------------------
// After reset the map RAM is swept to zero, one word a cycle, over all
// ceil(min(NUM_BLOCKS, 32768) / MAP_WORD_BITS) map words (512 at the defaults);
// requests wait until the sweep ends, configuration writes do not. A request
// is taken only when the previous one has finished, while an earlier result
// may still sit in the output register. A rejected request goes from the range
// check straight to the finish step; a free splits the block number into word
// and bit with a reciprocal multiply, then reads and rewrites its map word; an
// allocate splits the first data block the same way, then scans map words up
// to the hit, one word a cycle on the single read port of the map RAM, picks
// the lowest free bit and writes the word back. An allocate that finds nothing
// scans every word in the region. A result still waiting in the output
// register holds the last step until it is taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core
  import bba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS    = 32768,
  parameter int unsigned MAP_WORD_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [BLK_W-1:0] block_number_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [BLK_W-1:0] granted_block_o,
  output logic [CNT_W-1:0] free_count_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Map, counter and result datapath
  bba_dp #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .block_number_i  (block_number_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (status_o),
    .granted_block_o (granted_block_o),
    .free_count_o    (free_count_o)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bitmap_block_allocator_core. A ledger class keeps
// its own occupancy map, free-block count and register copies. It predicts
// the result of every accepted request, and every result beat is checked
// against the oldest prediction. Directed requests cover the region edges,
// an empty region, a full region, rejected frees and double frees. Random
// phases then retune the region and mix allocates with frees of granted
// blocks, while both handshake sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  typedef struct {
    status_e          status;
    logic [BLK_W-1:0] granted;
    logic [CNT_W-1:0] count;
  } grant_t;

  // Predicted allocator state and the queue of results still to arrive
  class block_map_ledger;
    bit               used [GRANT_SPAN];
    logic [CNT_W-1:0] spare_count;
    logic [CFG_W-1:0] first_data;
    logic [CFG_W-1:0] block_limit;
    grant_t           due [$];
    int unsigned      held [$];
    int               mismatches;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      spare_count = COUNTER_RESET;
      first_data  = FIRST_DATA_RESET;
      block_limit = LIMIT_RESET;
      mismatches  = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      if (idx == CFG_FIRST_DATA) first_data = value;
      else block_limit = value;
    endfunction

    // Clip the limit to the span that granted_block can name
    function int unsigned top_block();
      int unsigned lim;
      lim = block_limit;
      return (lim > GRANT_SPAN) ? GRANT_SPAN : lim;
    endfunction

    // Apply one accepted request beat and queue its result
    function void take_request(op_e op, logic [BLK_W-1:0] blk);
      int unsigned lim;
      grant_t      r;
      lim       = top_block();
      r.status  = STAT_NO_FREE;
      r.granted = '0;
      if (op == OP_ALLOC) begin
        // first fit from the bottom of the data region
        for (int unsigned i = first_data; i < lim; i++) begin
          if (!used[i]) begin
            used[i] = 1'b1;
            if (spare_count != 0) spare_count--;
            r.status  = STAT_DONE;
            r.granted = BLK_W'(i);
            held.push_back(i);
            break;
          end
        end
      end else if (blk < first_data || blk >= lim) begin
        r.status = STAT_OUT_OF_RANGE;
      end else begin
        // a double free still bumps the count
        used[blk] = 1'b0;
        if (spare_count != COUNTER_MAX) spare_count++;
        r.status = STAT_DONE;
        for (int k = 0; k < held.size(); k++) begin
          if (held[k] == blk) begin
            held.delete(k);
            break;
          end
        end
      end
      r.count = spare_count;
      due.push_back(r);
    endfunction

    // Compare one result beat with the oldest prediction
    function void match_result(logic [1:0] status, logic [BLK_W-1:0] granted,
                               logic [CNT_W-1:0] count);
      grant_t want;
      if (due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat: status %0d granted %0d count %0d",
                 $time, status, granted, count);
        return;
      end
      want = due.pop_front();
      if (status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, status);
      end
      if (granted !== want.granted) begin
        mismatches++;
        $display("%0t: granted_block mismatch: expected %0d actual %0d",
                 $time, want.granted, granted);
      end
      if (count !== want.count) begin
        mismatches++;
        $display("%0t: free_count mismatch: expected %0d actual %0d",
                 $time, want.count, count);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             operation_i;
  logic [BLK_W-1:0] block_number_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [1:0]       status_o;
  logic [BLK_W-1:0] granted_block_o;
  logic [CNT_W-1:0] free_count_o;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  block_map_ledger ledger;
  bit              send_calm;
  bit              take_calm;
  int unsigned     sent;

  bitmap_block_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .block_number_i  (block_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_block_o (granted_block_o),
    .free_count_o    (free_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Send one request beat after a random gap; valid stays high afterwards
  task automatic send_beat(op_e op, logic [BLK_W-1:0] blk);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    block_number_i <= blk;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    ledger.take_request(op, blk);
    sent++;
  endtask

  // Drain the block, then write both region registers
  task automatic retune(logic [CFG_W-1:0] first, logic [CFG_W-1:0] limit);
    in_valid_i <= 1'b0;
    while (ledger.due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FIRST_DATA;
    cfg_data_i <= first;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BLOCK_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_reg(CFG_FIRST_DATA, first);
    ledger.set_reg(CFG_BLOCK_LIMIT, limit);
  endtask

  // Result side: stall at random, check every beat taken
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = take_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      ledger.match_result(status_o, granted_block_o, free_count_o);
    end
  end

  // Request side and run control
  initial begin
    logic [CFG_W-1:0] first;
    logic [CFG_W-1:0] limit;
    int unsigned      top;
    int unsigned      len;
    int unsigned      pick;
    int unsigned      blk;

    ledger         = new();
    sent           = 0;
    send_calm      = 1'b0;
    take_calm      = 1'b0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    operation_i    <= OP_ALLOC;
    block_number_i <= '0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_FIRST_DATA;
    cfg_data_i     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset region: grant, reuse, range edges, double free at the top
    send_beat(OP_ALLOC, '0);
    send_beat(OP_ALLOC, '1);
    send_beat(OP_FREE, 15'd1033);
    send_beat(OP_ALLOC, 15'd0);
    send_beat(OP_FREE, 15'd1032);
    send_beat(OP_FREE, 15'd0);
    send_beat(OP_FREE, 15'h7FFF);
    send_beat(OP_FREE, 15'd1034);

    // Empty regions: nothing to grant, every free rejected
    retune(16'd0, 16'd0);
    send_beat(OP_ALLOC, 15'h2AAA);
    send_beat(OP_FREE, 15'd0);
    retune(16'd32768, 16'd32768);
    send_beat(OP_ALLOC, 15'h5555);
    send_beat(OP_FREE, 15'h7FFF);

    // Three-block region: fill it, hit full, free on both sides of it
    retune(16'd5, 16'd8);
    repeat (4) send_beat(OP_ALLOC, '0);
    send_beat(OP_FREE, 15'd8);
    send_beat(OP_FREE, 15'd4);
    send_beat(OP_FREE, 15'd6);
    send_beat(OP_ALLOC, '0);

    // Limit above the grant span clips to the top block
    retune(16'd32766, 16'hFFFF);
    repeat (3) send_beat(OP_ALLOC, '0);
    send_beat(OP_FREE, 15'h7FFF);
    send_beat(OP_FREE, 15'h5555);

    // Random phases, each with its own region and idling style
    while (sent < 1170) begin
      case ($urandom_range(0, 9))
        0: begin
          first = '0;
          limit = CFG_W'($urandom_range(1, 300));
        end
        1: begin
          first = CFG_W'($urandom_range(0, 32768));
          limit = CFG_W'($urandom_range(0, first));
        end
        2: begin
          first = CFG_W'($urandom_range(0, 32000));
          limit = $urandom_range(0, 1) ? 16'd32768 : 16'hFFFF;
        end
        3: begin
          first = CFG_W'($urandom_range(32500, 32767));
          limit = 16'd32768;
        end
        default: begin
          first = CFG_W'($urandom_range(0, 32600));
          limit = first + CFG_W'($urandom_range(1, 160));
        end
      endcase
      send_calm = ($urandom_range(0, 3) == 0);
      take_calm = ($urandom_range(0, 3) == 0);
      retune(first, limit);
      top = ledger.top_block();
      len = $urandom_range(8, 60);
      for (int n = 0; n < len; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          send_beat(OP_ALLOC, BLK_W'($urandom));
        end else if (pick < 8 && ledger.held.size() != 0) begin
          // prefer a granted block inside the current region
          blk = ledger.held[$urandom_range(0, ledger.held.size() - 1)];
          repeat (3) begin
            if (blk < first || blk >= top)
              blk = ledger.held[$urandom_range(0, ledger.held.size() - 1)];
          end
          send_beat(OP_FREE, BLK_W'(blk));
        end else if (pick < 9 && top > first) begin
          send_beat(OP_FREE, BLK_W'($urandom_range(first, top - 1)));
        end else begin
          send_beat(OP_FREE, BLK_W'($urandom));
        end
      end
    end

    // Drain, then give stray beats time to show up
    in_valid_i <= 1'b0;
    while (ledger.due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (ledger.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
